// ===== src/pfc8_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfc8_pkg
// Shared constants, types and the CRC-8 byte update for the packet framer.
// ----------------------------------------------------------------------------
package pfc8_pkg;

	localparam logic [7:0] SYNC_FIRST  = 8'h46;	// 'F'
	localparam logic [7:0] SYNC_SECOND = 8'h57;	// 'W'
	localparam logic [7:0] CRC_POLY    = 8'h07;

	// Most output bytes that one input transaction can cause
	localparam int GROUP_DEPTH = 7;
	localparam int CNT_W       = $clog2(GROUP_DEPTH + 1);

	// Output bytes waiting to leave, slot 0 goes first
	typedef struct packed {
		logic [GROUP_DEPTH-1:0][7:0] bytes;
		logic [GROUP_DEPTH-1:0]      ends;
		logic [CNT_W-1:0]            count;
	} group_t;

	// Framing state carried between transactions
	typedef struct packed {
		logic        in_packet;
		logic [15:0] bytes_left;
		logic [7:0]  crc;
	} frm_state_t;

	// CRC-8, MSB first, no reflection, no final xor
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] v;
		v = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (v[7]) begin
				v = {v[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				v = {v[6:0], 1'b0};
			end
		end
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== src/pfc8_frame.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfc8_frame
// Builds the output byte group for one payload byte and the next framing state.
// ----------------------------------------------------------------------------
module pfc8_frame import pfc8_pkg::*; (
	input  wire logic [7:0]  data_byte,
	input  wire logic [7:0]  packet_type,
	input  wire logic [15:0] payload_length,
	input  wire frm_state_t  cur,
	output group_t           grp,
	output frm_state_t       nxt
);

	logic [7:0]  hdr_crc;
	logic [7:0]  first_crc;
	logic [7:0]  mid_crc;
	logic [15:0] mid_left;

	// CRC over header and first byte, and the running update mid-packet
	assign hdr_crc   = crc8_update(crc8_update(crc8_update(8'h00, packet_type),
		payload_length[7:0]), payload_length[15:8]);
	assign first_crc = crc8_update(hdr_crc, data_byte);
	assign mid_crc   = crc8_update(cur.crc, data_byte);
	assign mid_left  = cur.bytes_left - 16'd1;

	// Fill the group and advance the state
	always_comb begin
		grp.bytes = '0;
		grp.ends  = '0;
		grp.count = '0;
		nxt.in_packet  = 1'b0;
		nxt.bytes_left = '0;
		nxt.crc        = '0;
		if (!cur.in_packet) begin
			grp.bytes[0] = SYNC_FIRST;
			grp.bytes[1] = SYNC_SECOND;
			grp.bytes[2] = packet_type;
			grp.bytes[3] = payload_length[7:0];
			grp.bytes[4] = payload_length[15:8];
			priority if (payload_length == 16'd0) begin
				// empty frame: drop the data byte, close on the header CRC
				grp.bytes[5] = hdr_crc;
				grp.ends[5]  = 1'b1;
				grp.count    = CNT_W'(6);
			end else if (payload_length == 16'd1) begin
				grp.bytes[5] = data_byte;
				grp.bytes[6] = first_crc;
				grp.ends[6]  = 1'b1;
				grp.count    = CNT_W'(7);
			end else begin
				grp.bytes[5]   = data_byte;
				grp.count      = CNT_W'(6);
				nxt.in_packet  = 1'b1;
				nxt.bytes_left = payload_length - 16'd1;
				nxt.crc        = first_crc;
			end
		end else begin
			grp.bytes[0] = data_byte;
			if (mid_left == 16'd0) begin
				grp.bytes[1] = mid_crc;
				grp.ends[1]  = 1'b1;
				grp.count    = CNT_W'(2);
			end else begin
				grp.count      = CNT_W'(1);
				nxt.in_packet  = 1'b1;
				nxt.bytes_left = mid_left;
				nxt.crc        = mid_crc;
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/packet_framer_crc8_core.sv =====
// Latency: the first output byte of a transaction is offered in the cycle after it is accepted.
// Throughput: mid-packet bytes pass at one per cycle while out_ready is high; the first byte of a
// packet queues a group of 6 or 7 bytes and a closing byte a group of 2, and the input then waits
// while the one-byte output port drains the result group register down to its last byte.
// Reset: arst_n clears the framing state and empties the result group; no clearing pass.
`default_nettype none
// ----------------------------------------------------------------------------
// packet_framer_crc8_core
// Frames payload bytes into sync, type, length, payload and CRC-8 trailer.
// ----------------------------------------------------------------------------
module packet_framer_crc8_core import pfc8_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic [7:0]  packet_type,
	input  wire logic [15:0] payload_length,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       out_byte,
	output logic             frame_end
);

	frm_state_t            state_q;
	frm_state_t            state_nxt;
	group_t                grp_new;
	logic [GROUP_DEPTH-1:0][7:0] bytes_q;
	logic [GROUP_DEPTH-1:0]      ends_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  in_acc;
	logic                  out_acc;

	pfc8_frame u_frame (
		.data_byte      (data_byte),
		.packet_type    (packet_type),
		.payload_length (payload_length),
		.cur            (state_q),
		.grp            (grp_new),
		.nxt            (state_nxt)
	);

	// Take a transaction when the group is empty or its last byte leaves now
	assign out_valid = (cnt_q != '0);
	assign out_acc   = out_valid && out_ready;
	assign in_ready  = !out_valid || (out_ready && cnt_q == CNT_W'(1));
	assign in_acc    = in_valid && in_ready;
	assign out_byte  = bytes_q[0];
	assign frame_end = ends_q[0];

	// Hold the framing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (in_acc) begin
			state_q <= state_nxt;
		end
	end

	// Track the number of bytes still to send
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_acc) begin
			cnt_q <= grp_new.count;
		end else if (out_acc) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// Load a new group or shift the current one down a slot
	always_ff @(posedge clk) begin
		if (in_acc) begin
			bytes_q <= grp_new.bytes;
			ends_q  <= grp_new.ends;
		end else if (out_acc) begin
			for (int i = 0; i < GROUP_DEPTH - 1; i++) begin
				bytes_q[i] <= bytes_q[i+1];
				ends_q[i]  <= ends_q[i+1];
			end
			bytes_q[GROUP_DEPTH-1] <= '0;
			ends_q[GROUP_DEPTH-1]  <= 1'b0;
		end
	end

	// A frame ends only on the last byte of its group, with the framer idle
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> cnt_q == CNT_W'(1))
		else $error("frame end not on the last queued byte");

	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> !state_q.in_packet)
		else $error("frame end while a packet is still open");

	// A packet start queues the full header
	a_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !state_q.in_packet |=> cnt_q == CNT_W'(6) || cnt_q == CNT_W'(7))
		else $error("header group has the wrong size");

	a_left: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.in_packet |-> state_q.bytes_left != 16'd0)
		else $error("open packet with no bytes left");

endmodule
`default_nettype wire

// ===== tb/packet_framer_crc8_core_check.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// packet_framer_crc8_core_check
// Watches both channels of the framer, builds the expected framed byte
// stream from every input transaction and compares each output transaction
// against it in order.
// ----------------------------------------------------------------------------
module packet_framer_crc8_core_check import pfc8_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic [7:0]  packet_type,
	input  wire logic [15:0] payload_length,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [7:0]  out_byte,
	input  wire logic        frame_end,
	output int               errors,
	output int               pending,
	output int               bytes_checked
);

	typedef struct packed {
		logic [7:0] octet;
		logic       last;
	} framed_byte_t;

	// Bytes the framer still owes, oldest first
	framed_byte_t frame_bytes_due[$];

	// Own copy of the framing state
	logic        in_frame;
	logic [15:0] remaining;
	logic [7:0]  crc_run;
	int          err_n;
	int          seen_n;

	// Shift one byte into the CRC, one bit at a time, MSB first
	function automatic logic [7:0] crc8_shift_in(input logic [7:0] acc, input logic [7:0] b);
		logic [7:0] r;
		logic       fb;
		r = acc;
		for (int i = 7; i >= 0; i--) begin
			fb = r[7] ^ b[i];
			r = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
		end
		return r;
	endfunction

	task automatic owe(input logic [7:0] b, input logic e);
		frame_bytes_due.push_back('{octet: b, last: e});
	endtask

	// Work out every byte one accepted input transaction causes
	task automatic frame_input(input logic [7:0] d, input logic [7:0] t, input logic [15:0] l);
		logic [7:0] c;
		if (!in_frame) begin
			owe(SYNC_FIRST, 1'b0);
			owe(SYNC_SECOND, 1'b0);
			owe(t, 1'b0);
			owe(l[7:0], 1'b0);
			owe(l[15:8], 1'b0);
			c = crc8_shift_in(8'h00, t);
			c = crc8_shift_in(c, l[7:0]);
			c = crc8_shift_in(c, l[15:8]);
			if (l == 16'd0) begin
				// empty frame: drop the data byte, stay idle
				owe(c, 1'b1);
				crc_run = 8'h00;
				remaining = 16'd0;
			end else begin
				owe(d, 1'b0);
				c = crc8_shift_in(c, d);
				remaining = l - 16'd1;
				if (remaining == 16'd0) begin
					owe(c, 1'b1);
					crc_run = 8'h00;
				end else begin
					crc_run = c;
					in_frame = 1'b1;
				end
			end
		end else begin
			owe(d, 1'b0);
			crc_run = crc8_shift_in(crc_run, d);
			remaining = remaining - 16'd1;
			if (remaining == 16'd0) begin
				owe(crc_run, 1'b1);
				crc_run = 8'h00;
				in_frame = 1'b0;
			end
		end
	endtask

	// Compare output transactions first, then predict from the input one
	always @(posedge clk or negedge arst_n) begin
		framed_byte_t head;
		if (!arst_n) begin
			in_frame = 1'b0;
			remaining = 16'd0;
			crc_run = 8'h00;
			err_n = 0;
			seen_n = 0;
			frame_bytes_due.delete();
			errors <= 0;
			pending <= 0;
			bytes_checked <= 0;
		end else begin
			if (out_valid && out_ready) begin
				seen_n++;
				if (frame_bytes_due.size() == 0) begin
					if (err_n < 40)
						$display("%0t: unexpected out_byte %02h frame_end %0b, nothing due",
							$time, out_byte, frame_end);
					err_n++;
				end else begin
					head = frame_bytes_due.pop_front();
					if (out_byte !== head.octet) begin
						if (err_n < 40)
							$display("%0t: out_byte expected %02h, got %02h",
								$time, head.octet, out_byte);
						err_n++;
					end
					if (frame_end !== head.last) begin
						if (err_n < 40)
							$display("%0t: frame_end expected %0b, got %0b",
								$time, head.last, frame_end);
						err_n++;
					end
				end
			end
			if (in_valid && in_ready)
				frame_input(data_byte, packet_type, payload_length);
			errors <= err_n;
			pending <= frame_bytes_due.size();
			bytes_checked <= seen_n;
		end
	end

endmodule
`default_nettype wire

// ===== tb/packet_framer_crc8_core_test.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// packet_framer_crc8_core_test
// Drives payload bytes into the framer as directed cases and random packets,
// with random gaps on both channels; a checker beside the block predicts and
// compares every framed byte.
// ----------------------------------------------------------------------------
module packet_framer_crc8_core_test;

	typedef enum int {
		IDLE_NORMAL,
		IDLE_NONE
	} idle_mode_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic [7:0]  packet_type;
	logic [15:0] payload_length;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  out_byte;
	logic        frame_end;

	int          errors;
	int          pending;
	int          bytes_checked;

	idle_mode_t  idle_mode;
	int          items_sent;
	int          frames_sent;
	int          empty_sent;

	packet_framer_crc8_core uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.packet_type    (packet_type),
		.payload_length (payload_length),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.frame_end      (frame_end)
	);

	packet_framer_crc8_core_check checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.packet_type    (packet_type),
		.payload_length (payload_length),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.frame_end      (frame_end),
		.errors         (errors),
		.pending        (pending),
		.bytes_checked  (bytes_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run
	initial begin
		#25_000_000;
		$display("timeout with %0d bytes still due", pending);
		$display("packet_framer_crc8_core_test: errors");
		$finish;
	end

	// Idle length for either side: mostly short, now and then long
	function automatic int pick_gap(input idle_mode_t m);
		int r;
		r = $urandom_range(0, 99);
		case (m)
			IDLE_NONE: begin
				return 0;
			end
			default: begin
				if (r < 45)
					return 0;
				else if (r < 85)
					return $urandom_range(1, 3);
				else if (r < 95)
					return $urandom_range(4, 8);
				else
					return $urandom_range(20, 40);
			end
		endcase
	endfunction

	// Offer one input transaction and hold it until accepted
	task automatic send_byte(input logic [7:0] d, input logic [7:0] t, input logic [15:0] l);
		int gap;
		gap = pick_gap(idle_mode);
		if (gap > 0) begin
			in_valid <= 1'b0;
			data_byte <= 8'($urandom_range(0, 255));
			packet_type <= 8'($urandom_range(0, 255));
			payload_length <= 16'($urandom_range(0, 65535));
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= d;
		packet_type <= t;
		payload_length <= l;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
	endtask

	// Send a whole packet; type and length after the first byte are noise
	task automatic send_packet(input logic [7:0] t, input logic [15:0] l);
		send_byte(8'($urandom_range(0, 255)), t, l);
		for (int i = 1; i < l; i++)
			send_byte(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				16'($urandom_range(0, 65535)));
		frames_sent++;
		if (l == 16'd0)
			empty_sent++;
	endtask

	// Receiver: accept in runs, stall in between
	initial begin
		int run;
		int stall;
		out_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			out_ready <= 1'b1;
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
			repeat (run) @(posedge clk);
			stall = pick_gap(idle_mode);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// Stimulus and verdict
	initial begin
		int          k;
		int          w;
		int          fails;
		logic [15:0] len;
		idle_mode = IDLE_NORMAL;
		items_sent = 0;
		frames_sent = 0;
		empty_sent = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		data_byte <= 8'h00;
		packet_type <= 8'h00;
		payload_length <= 16'd0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one-byte packets at the field extremes
		send_byte(8'h00, 8'h00, 16'd1);
		send_byte(8'hFF, 8'hFF, 16'd1);
		// empty frames: data byte dropped
		send_byte(8'h3C, 8'hA5, 16'd0);
		send_byte(8'hFF, 8'h00, 16'd0);
		// type and length change mid-packet and must be ignored
		send_byte(8'h80, 8'h12, 16'd3);
		send_byte(8'h01, 8'hEE, 16'd0);
		send_byte(8'h7F, 8'h55, 16'hFFFF);
		send_byte(8'hFF, 8'h81, 16'd2);
		send_byte(8'h00, 8'h00, 16'd1);
		// empty frame straight after a packet closes
		send_byte(8'hAA, 8'h7E, 16'd0);
		send_byte(8'h01, 8'h5A, 16'd5);
		send_byte(8'h02, 8'h00, 16'h8000);
		send_byte(8'h04, 8'hFF, 16'h0001);
		send_byte(8'h08, 8'h33, 16'h7FFF);
		send_byte(8'hF0, 8'hCC, 16'd0);
		// back to back with no idling
		idle_mode = IDLE_NONE;
		send_byte(8'hC3, 8'h96, 16'd1);
		send_byte(8'h69, 8'h69, 16'd1);
		frames_sent += 10;
		empty_sent += 3;

		// random packets, mostly short
		while (items_sent < 350) begin
			idle_mode = ($urandom_range(0, 99) < 15) ? IDLE_NONE : IDLE_NORMAL;
			k = $urandom_range(0, 99);
			if (k < 8)
				len = 16'd0;
			else if (k < 60)
				len = 16'($urandom_range(1, 6));
			else if (k < 90)
				len = 16'($urandom_range(7, 24));
			else
				len = 16'($urandom_range(25, 64));
			send_packet(8'($urandom_range(0, 255)), len);
		end
		in_valid <= 1'b0;
		idle_mode = IDLE_NORMAL;

		// drain, then allow a few cycles for stray output
		@(posedge clk);
		w = 0;
		while (pending != 0 && w < 4000) begin
			@(posedge clk);
			w++;
		end
		repeat (16) @(posedge clk);

		fails = errors;
		if (pending != 0) begin
			$display("%0t: %0d expected bytes never arrived", $time, pending);
			fails += pending;
		end
		$display("covered %0d input transactions in %0d frames (%0d empty)",
			items_sent, frames_sent, empty_sent);
		$display("checked %0d framed output bytes, %0d failures", bytes_checked, fails);
		if (fails == 0)
			$display("packet_framer_crc8_core_test: clean");
		else
			$display("packet_framer_crc8_core_test: errors");
		$finish;
	end

endmodule
`default_nettype wire
